@@ hw/rtl/tocs_pkg.sv @@
// Types, register indexes, cost byte codes and sequencer states of the
// trajectory obstacle cost scorer. No dependencies.
`default_nettype none

package tocs_pkg;

   localparam int MAX_TRAJ_POINTS = 256;
   localparam int MAX_POWER       = 4;

   localparam int COST_W   = 48;
   localparam int SUM_W    = 32;
   localparam int AMT_W    = 19;
   localparam int NUM_W    = 64;
   localparam int DEN_W    = 25;
   localparam int NORM_DIV = 130048;
   localparam int DIG_W    = 16;
   localparam int PROD_W   = 2 * COST_W;
   localparam int CNT_W    = 6;

   localparam logic [COST_W-1:0] Q_MAX = '1;

   localparam logic [2:0] CSR_ENABLE            = 3'd0;
   localparam logic [2:0] CSR_FOOTPRINT_MODE    = 3'd1;
   localparam logic [2:0] CSR_COST_POWER        = 3'd2;
   localparam logic [2:0] CSR_COST_WEIGHT       = 3'd3;
   localparam logic [2:0] CSR_CRITICAL_COST     = 3'd4;
   localparam logic [2:0] CSR_COLLISION_COST    = 3'd5;
   localparam logic [2:0] CSR_TRAJECTORY_LENGTH = 3'd6;

   localparam logic [7:0] COST_FREE       = 8'd0;
   localparam logic [7:0] COST_HIGH_LIMIT = 8'd235;
   localparam logic [7:0] COST_INSCRIBED  = 8'd253;
   localparam logic [7:0] COST_LETHAL     = 8'd254;
   localparam logic [7:0] COST_UNKNOWN    = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_ROUND,
      ST_POW,
      ST_NORM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [7:0] point_cost;
      logic       goal_close;
      logic       last_point;
      logic       last_trajectory;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] trajectory_cost;
      logic              collided;
      logic              all_collided;
      logic              batch_end;
   } rsp_type;

   typedef struct packed {
      logic req_ready;
      logic load_num;
      logic div_step;
      logic round;
      logic pow_step;
      logic norm;
      logic finish;
   } ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/trajectory_obstacle_cost_scorer_top.sv @@
// Trajectory obstacle cost scorer: accumulates per-point cost bytes and scores
// each trajectory with one shared 48x16 multiplier and a radix-2 divider.
// Depends on tocs_pkg.
//   req channel: one item per trajectory point (cost byte, near-goal flag,
//   last-point and last-trajectory markers). Points that are not the last of
//   a trajectory are taken one per cycle.
//   rsp channel: one item per trajectory, produced after its last point.
//   csr port: plain write port, registers 0..6, user writes when idle (unenforced).
//   From the last point to the result the sequencer runs a multiply step,
//   64 divide iterations (one quotient bit each) and a rounding step, then,
//   for each of the p-1 further power steps (p being the effective cost power,
//   1..4), three 16-bit partial products and a rounding step, and finally
//   loads the output register; when disabled it only loads the output
//   register. req_ready is low during that time. The divider's bit count and
//   the multiplier's digit sweep set its length.
//   A finished result sits in the output register; new points are taken
//   while it waits. If the receiver stalls and a second result is ready, the
//   sequencer holds in its last state until the output register frees.
//   Reset (synchronous, active high) loads the register defaults, clears the
//   running sum and hit flag, sets all_hit and drops rsp_valid; req_ready is low.
`default_nettype none

module trajectory_obstacle_cost_scorer_top
   import tocs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data,
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_index,
   input  wire logic [23:0]   csr_wdata
);

   logic               en_ff, fp_ff;
   logic [2:0]         pow_ff;
   logic [15:0]        weight_ff, crit_ff;
   logic [23:0]        coll_ff;
   logic [8:0]         len_ff;

   state_type          state_ff, state_in;
   ctl_type            ctl;

   logic [SUM_W-1:0]   cost_sum_ff, cost_sum_in;
   logic               hit_ff, hit_in;
   logic               all_hit_ff, all_hit_in;
   logic               last_tr_ff, last_tr_in;

   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [COST_W-1:0]  base_ff, base_in;
   logic [COST_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         dig_ff, dig_in;
   logic [2:0]         pw_cnt_ff, pw_cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept, out_free;
   logic [8:0]         len_eff;
   logic [2:0]         pw_eff;
   logic [DEN_W-1:0]   den_calc;
   logic               pt_hit;
   logic [AMT_W-1:0]   amount;
   logic [SUM_W:0]     sum_add;
   logic [SUM_W-1:0]   s_sel;
   logic [COST_W-1:0]  mul_a;
   logic [DIG_W-1:0]   mul_b;
   logic [NUM_W-1:0]   mul_out;
   logic [DEN_W:0]     rem_sh;
   logic               rem_ge;
   logic               rnd_up;
   logic [NUM_W:0]     q_rnd;
   logic [COST_W-1:0]  q_sat;
   logic [PROD_W-1:0]  prod_rnd;

   assign accept   = req_valid && ctl.req_ready && !reset;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctl.req_ready && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff     <= 1'b1;
         fp_ff     <= 1'b0;
         pow_ff    <= 3'd1;
         weight_ff <= 16'd976;
         crit_ff   <= 16'd300;
         coll_ff   <= 24'd1000000;
         len_ff    <= 9'd56;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:            en_ff     <= csr_wdata[0];
            CSR_FOOTPRINT_MODE:    fp_ff     <= csr_wdata[0];
            CSR_COST_POWER:        pow_ff    <= csr_wdata[2:0];
            CSR_COST_WEIGHT:       weight_ff <= csr_wdata[15:0];
            CSR_CRITICAL_COST:     crit_ff   <= csr_wdata[15:0];
            CSR_COLLISION_COST:    coll_ff   <= csr_wdata;
            CSR_TRAJECTORY_LENGTH: len_ff    <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (len_ff == 9'd0) begin
         len_eff = 9'd1;
      end else if (int'(len_ff) > MAX_TRAJ_POINTS) begin
         len_eff = 9'(MAX_TRAJ_POINTS);
      end else begin
         len_eff = len_ff;
      end
      if (pow_ff == 3'd0) begin
         pw_eff = 3'd1;
      end else if (int'(pow_ff) > MAX_POWER) begin
         pw_eff = 3'(MAX_POWER);
      end else begin
         pw_eff = pow_ff;
      end
   end

   assign den_calc = DEN_W'(NORM_DIV * int'(len_eff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.last_point) begin
               state_in = en_ff ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL:   state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: state_in = (pw_eff == 3'd1) ? ST_DONE : ST_POW;
         ST_POW: begin
            if (dig_ff == 2'd0) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM:  state_in = (pw_cnt_ff == 3'd1) ? ST_DONE : ST_POW;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE:  ctl.req_ready = 1'b1;
         ST_MUL:   ctl.load_num  = 1'b1;
         ST_DIV:   ctl.div_step  = 1'b1;
         ST_ROUND: ctl.round     = 1'b1;
         ST_POW:   ctl.pow_step  = 1'b1;
         ST_NORM:  ctl.norm      = 1'b1;
         ST_DONE:  ctl.finish    = out_free;
         default:  ctl = '0;
      endcase
   end

   // point cost
   always_comb begin
      pt_hit = (req_data.point_cost == COST_LETHAL) ||
               (req_data.point_cost == COST_INSCRIBED && !fp_ff);
      if (req_data.point_cost == COST_UNKNOWN) begin
         amount = {1'b0, crit_ff, 2'b00} + {2'b00, crit_ff, 1'b0};
      end else if (req_data.point_cost > COST_HIGH_LIMIT) begin
         amount = {2'b00, crit_ff, 1'b0} + {3'b000, crit_ff};
      end else if (!req_data.goal_close) begin
         amount = {10'd0, req_data.point_cost, 1'b0};
      end else begin
         amount = '0;
      end
      sum_add = {1'b0, cost_sum_ff} + (SUM_W + 1)'(amount);
   end

   // shared multiplier
   assign s_sel = hit_ff ? {7'd0, coll_ff, 1'b0} : cost_sum_ff;

   always_comb begin
      if (ctl.load_num) begin
         mul_a = COST_W'(s_sel);
         mul_b = weight_ff;
      end else begin
         mul_a = acc_ff;
         case (dig_ff)
            2'd0:    mul_b = base_ff[15:0];
            2'd1:    mul_b = base_ff[31:16];
            2'd2:    mul_b = base_ff[47:32];
            default: mul_b = '0;
         endcase
      end
   end

   assign mul_out = NUM_W'(mul_a) * NUM_W'(mul_b);

   // divider step and rounding
   assign rem_sh   = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, den_ff};
   assign rnd_up   = {rem_ff, 1'b0} >= (DEN_W + 2)'(den_ff);
   assign q_rnd    = {1'b0, num_ff} + (NUM_W + 1)'(rnd_up);
   assign q_sat    = (|q_rnd[NUM_W:COST_W]) ? Q_MAX : q_rnd[COST_W-1:0];
   assign prod_rnd = prod_ff + PROD_W'(17'h08000);

   always_comb begin
      cost_sum_in  = cost_sum_ff;
      hit_in       = hit_ff;
      all_hit_in   = all_hit_ff;
      last_tr_in   = last_tr_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      pw_cnt_in    = pw_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (accept) begin
         last_tr_in = req_data.last_trajectory;
         if (en_ff && !hit_ff && req_data.point_cost != COST_FREE) begin
            if (pt_hit) begin
               hit_in = 1'b1;
            end else begin
               cost_sum_in = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            end
         end
      end

      if (ctl.load_num) begin
         num_in = {mul_out[COST_W-1:0], 16'd0};
         rem_in = '0;
         den_in = den_calc;
         cnt_in = '0;
      end

      if (ctl.div_step) begin
         rem_in = rem_ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         num_in = {num_ff[NUM_W-2:0], rem_ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (ctl.round) begin
         base_in   = q_sat;
         acc_in    = q_sat;
         pw_cnt_in = pw_eff - 3'd1;
         dig_in    = 2'd2;
         prod_in   = '0;
      end

      if (ctl.pow_step) begin
         prod_in = {prod_ff[PROD_W-DIG_W-1:0], {DIG_W{1'b0}}} + PROD_W'(mul_out);
         dig_in  = dig_ff - 2'd1;
      end

      if (ctl.norm) begin
         acc_in    = (|prod_rnd[PROD_W-1:NUM_W]) ? Q_MAX : prod_rnd[NUM_W-1:DIG_W];
         pw_cnt_in = pw_cnt_ff - 3'd1;
         dig_in    = 2'd2;
         prod_in   = '0;
      end

      if (ctl.finish) begin
         rsp_in.trajectory_cost = en_ff ? acc_ff : '0;
         rsp_in.collided        = en_ff && hit_ff;
         rsp_in.all_collided    = last_tr_ff && en_ff && all_hit_ff && hit_ff;
         rsp_in.batch_end       = last_tr_ff;
         rsp_valid_in           = 1'b1;
         all_hit_in             = last_tr_ff || (en_ff && all_hit_ff && hit_ff);
         cost_sum_in            = '0;
         hit_in                 = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cost_sum_ff  <= '0;
         hit_ff       <= 1'b0;
         all_hit_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cost_sum_ff  <= cost_sum_in;
         hit_ff       <= hit_in;
         all_hit_ff   <= all_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_tr_ff <= last_tr_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      cnt_ff     <= cnt_in;
      dig_ff     <= dig_in;
      pw_cnt_ff  <= pw_cnt_in;
      rsp_ff     <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_ROUND) |-> rem_ff < {1'b0, den_ff})
      else $error("divider remainder not below divisor");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNT_W'(NUM_W - 1)) |=> state_ff == ST_ROUND)
      else $error("divider did not end after the last quotient bit");

   a_all_implies_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.all_collided || (rsp_ff.collided && rsp_ff.batch_end)))
      else $error("all_collided without collided or batch_end");

   a_finish_frees: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> state_ff == ST_IDLE && rsp_valid_ff && cost_sum_ff == '0 && !hit_ff)
      else $error("trajectory state not cleared after result");
`endif

endmodule

`default_nettype wire
